@@ sv/tcla_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and codes of the token character length aligner.
package tcla_pkg;

    localparam int TOKEN_LENGTH_W = 10;
    localparam int INDEX_OUT_W    = 8;

    typedef enum logic [1:0] {
        CMD_LOAD_SPLIT   = 2'd0,
        CMD_LOAD_UNSPLIT = 2'd1,
        CMD_FETCH        = 2'd2,
        CMD_NEW_LINE     = 2'd3
    } tcla_cmd_t;

    typedef enum logic [1:0] {
        STATUS_PAIR      = 2'd0,
        STATUS_IGNORED   = 2'd1,
        STATUS_EXHAUSTED = 2'd2
    } tcla_status_t;

    typedef enum logic [1:0] {
        PH_LOADING = 2'd0,
        PH_STREAM  = 2'd1,
        PH_DONE    = 2'd2
    } tcla_phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK_RD,
        ST_WALK_ADD,
        ST_OPEN,
        ST_EMIT
    } tcla_state_t;

    typedef struct packed {
        tcla_cmd_t                 command;
        logic [TOKEN_LENGTH_W-1:0] token_length;
    } tcla_in_t;

    typedef struct packed {
        logic [INDEX_OUT_W-1:0] split_index;
        logic [INDEX_OUT_W-1:0] unsplit_index;
        logic                   pair_valid;
        logic                   last;
        tcla_status_t           status;
    } tcla_out_t;

endpackage

@@ sv/tcla_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module tcla_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ sv/token_char_length_aligner.sv @@
`timescale 1ns / 1ps
// Top level of the token character length aligner.
//
// Load the token lengths of the split and the unsplit tokenization of one line
// (commands 0 and 1), then issue fetch commands: each fetch returns one item,
// an aligned index pair (split, unsplit) in group order with last set on the
// final pair, "line ignored" when the character counts of the two
// tokenizations disagree or the length store overflowed, or "no pairs left"
// once the stream is used up. A new line command clears the line. The lengths
// live in two RAMs with a registered read, and every step of the two-pointer
// walk is a read state followed by an add state. A fetch inside a group is
// accepted, then emitted. The first fetch of a line first runs the check walk
// over the whole line, then the walk of the first group; a fetch that
// finishes a group also runs the walk to the next match point. Results wait
// in an output register, so loads go on while a result is still not taken.
// There is no clearing pass: the stores are read only below the fill counts.
module token_char_length_aligner
    import tcla_pkg::*;
#(
    parameter int MAX_TOKENS  = 256,
    parameter int LENGTH_BITS = 10
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  tcla_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output tcla_out_t m_data
);

    localparam int IDX_W = $clog2(MAX_TOKENS);
    localparam int CNT_W = $clog2(MAX_TOKENS + 1);
    localparam int POS_W = LENGTH_BITS + CNT_W;

    // decision of one walk step
    typedef struct packed {
        logic adv_s;
        logic adv_u;
        logic finish;
        logic fail;
    } walk_dec_t;

    tcla_state_t state_reg, state_next;
    tcla_phase_t phase_reg, phase_next;

    logic [CNT_W-1:0] split_count_reg, split_count_next;
    logic [CNT_W-1:0] unsplit_count_reg, unsplit_count_next;
    logic             overflow_reg, overflow_next;
    logic             ignored_reg, ignored_next;
    logic [CNT_W-1:0] walk_s_reg, walk_s_next;
    logic [CNT_W-1:0] walk_u_reg, walk_u_next;
    logic [POS_W-1:0] pos_s_reg, pos_s_next;
    logic [POS_W-1:0] pos_u_reg, pos_u_next;
    logic [CNT_W-1:0] grp_s_reg, grp_s_next;
    logic [CNT_W-1:0] grp_u_reg, grp_u_next;
    logic [CNT_W-1:0] cur_s_reg, cur_s_next;
    logic [CNT_W-1:0] cur_u_reg, cur_u_next;
    logic             group_mode_reg, group_mode_next;   // 0 check walk, 1 group walk
    logic             first_open_reg, first_open_next;   // group opened by a line's first fetch
    logic             adv_s_reg, adv_s_next;
    logic             adv_u_reg, adv_u_next;
    logic             m_valid_reg, m_valid_next;
    tcla_out_t        m_data_reg, m_data_next;

    // RAM ports
    logic                   we_s, we_u;
    logic [LENGTH_BITS-1:0] wr_len;
    logic [LENGTH_BITS-1:0] rd_s, rd_u;

    logic [LENGTH_BITS+TOKEN_LENGTH_W-1:0] len_ext;
    logic [INDEX_OUT_W+CNT_W-1:0]          idx_s_ext, idx_u_ext;

    logic      accept;
    logic      out_free;
    logic      s_lt, u_lt, pos_eq, pos_lt;
    logic      more_groups;
    logic      split_room, unsplit_room;
    logic [CNT_W-1:0] cur_s_inc, cur_u_inc;
    walk_dec_t dec;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // keep the low LENGTH_BITS of the loaded length, zero-extend if wider
    assign len_ext = {LENGTH_BITS'(0), s_data.token_length};
    assign wr_len  = len_ext[LENGTH_BITS-1:0];

    assign idx_s_ext = {INDEX_OUT_W'(0), cur_s_reg};
    assign idx_u_ext = {INDEX_OUT_W'(0), cur_u_reg};

    assign s_lt        = walk_s_reg < split_count_reg;
    assign u_lt        = walk_u_reg < unsplit_count_reg;
    assign pos_eq      = pos_s_reg == pos_u_reg;
    assign pos_lt      = pos_s_reg < pos_u_reg;
    assign more_groups = s_lt && u_lt;
    assign split_room   = split_count_reg < CNT_W'(MAX_TOKENS);
    assign unsplit_room = unsplit_count_reg < CNT_W'(MAX_TOKENS);
    assign cur_s_inc   = cur_s_reg + CNT_W'(1);
    assign cur_u_inc   = cur_u_reg + CNT_W'(1);

    // Writes happen only in idle while loading; read data is used only during walks
    // with the input held off, so no used read ever meets a write to the same entry.
    tcla_ram #(.WIDTH(LENGTH_BITS), .DEPTH(MAX_TOKENS)) u_split_ram (
        .aclk  (aclk),
        .we    (we_s),
        .waddr (split_count_reg[IDX_W-1:0]),
        .wdata (wr_len),
        .raddr (walk_s_reg[IDX_W-1:0]),
        .rdata (rd_s)
    );

    tcla_ram #(.WIDTH(LENGTH_BITS), .DEPTH(MAX_TOKENS)) u_unsplit_ram (
        .aclk  (aclk),
        .we    (we_u),
        .waddr (unsplit_count_reg[IDX_W-1:0]),
        .wdata (wr_len),
        .raddr (walk_u_reg[IDX_W-1:0]),
        .rdata (rd_u)
    );

    // One walk step: advance the lagging side, or both from a match point
    // during the check walk.
    always_comb begin
        dec = '0;
        if (!group_mode_reg) begin
            priority if (pos_eq) begin
                if (s_lt) begin
                    if (!u_lt) begin
                        dec.finish = 1'b1;
                        dec.fail   = 1'b1;
                    end else begin
                        dec.adv_s = 1'b1;
                        dec.adv_u = 1'b1;
                    end
                end else begin
                    // unsplit tokens left over at the end is a mismatch
                    dec.finish = 1'b1;
                    dec.fail   = u_lt;
                end
            end else if (pos_lt) begin
                if (!s_lt) begin
                    dec.finish = 1'b1;
                    dec.fail   = 1'b1;
                end else begin
                    dec.adv_s = 1'b1;
                end
            end else begin
                if (!u_lt) begin
                    dec.finish = 1'b1;
                    dec.fail   = 1'b1;
                end else begin
                    dec.adv_u = 1'b1;
                end
            end
        end else begin
            priority if (pos_eq) begin
                dec.finish = 1'b1;
            end else if (pos_lt) begin
                dec.finish = !s_lt;
                dec.adv_s  = s_lt;
            end else begin
                dec.finish = !u_lt;
                dec.adv_u  = u_lt;
            end
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && s_data.command == CMD_FETCH) begin
                    if (phase_reg == PH_LOADING && !overflow_reg) begin
                        state_next = ST_WALK_RD;
                    end else begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_WALK_RD: begin
                if (dec.finish) begin
                    if (group_mode_reg) begin
                        state_next = first_open_reg ? ST_EMIT : ST_IDLE;
                    end else begin
                        state_next = dec.fail ? ST_EMIT : ST_OPEN;
                    end
                end else begin
                    state_next = ST_WALK_ADD;
                end
            end
            ST_WALK_ADD: begin
                state_next = ST_WALK_RD;
            end
            ST_OPEN: begin
                if (more_groups) begin
                    state_next = ST_WALK_ADD;
                end else begin
                    state_next = first_open_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                    if (!ignored_reg && phase_reg == PH_STREAM && cur_u_inc >= walk_u_reg &&
                        cur_s_inc >= walk_s_reg && more_groups) begin
                        state_next = ST_OPEN;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        phase_next         = phase_reg;
        split_count_next   = split_count_reg;
        unsplit_count_next = unsplit_count_reg;
        overflow_next      = overflow_reg;
        ignored_next       = ignored_reg;
        walk_s_next        = walk_s_reg;
        walk_u_next        = walk_u_reg;
        pos_s_next         = pos_s_reg;
        pos_u_next         = pos_u_reg;
        grp_s_next         = grp_s_reg;
        grp_u_next         = grp_u_reg;
        cur_s_next         = cur_s_reg;
        cur_u_next         = cur_u_reg;
        group_mode_next    = group_mode_reg;
        first_open_next    = first_open_reg;
        adv_s_next         = adv_s_reg;
        adv_u_next         = adv_u_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        m_data_next        = m_data_reg;
        we_s               = 1'b0;
        we_u               = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_data.command)
                        CMD_LOAD_SPLIT: begin
                            if (phase_reg == PH_LOADING) begin
                                if (split_room) begin
                                    we_s             = 1'b1;
                                    split_count_next = split_count_reg + CNT_W'(1);
                                end else begin
                                    overflow_next = 1'b1;
                                end
                            end
                        end
                        CMD_LOAD_UNSPLIT: begin
                            if (phase_reg == PH_LOADING) begin
                                if (unsplit_room) begin
                                    we_u               = 1'b1;
                                    unsplit_count_next = unsplit_count_reg + CNT_W'(1);
                                end else begin
                                    overflow_next = 1'b1;
                                end
                            end
                        end
                        CMD_FETCH: begin
                            if (phase_reg == PH_LOADING) begin
                                if (overflow_reg) begin
                                    ignored_next = 1'b1;
                                    phase_next   = PH_DONE;
                                end else begin
                                    group_mode_next = 1'b0;
                                    first_open_next = 1'b1;
                                end
                            end
                        end
                        CMD_NEW_LINE: begin
                            split_count_next   = '0;
                            unsplit_count_next = '0;
                            overflow_next      = 1'b0;
                            ignored_next       = 1'b0;
                            phase_next         = PH_LOADING;
                            walk_s_next        = '0;
                            walk_u_next        = '0;
                            pos_s_next         = '0;
                            pos_u_next         = '0;
                            grp_s_next         = '0;
                            grp_u_next         = '0;
                            cur_s_next         = '0;
                            cur_u_next         = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_WALK_RD: begin
                adv_s_next = dec.adv_s;
                adv_u_next = dec.adv_u;
                if (dec.finish) begin
                    if (!group_mode_reg) begin
                        if (dec.fail) begin
                            ignored_next = 1'b1;
                            phase_next   = PH_DONE;
                        end else begin
                            // restart from the line start for the first group
                            walk_s_next     = '0;
                            walk_u_next     = '0;
                            pos_s_next      = '0;
                            pos_u_next      = '0;
                            group_mode_next = 1'b1;
                        end
                    end else if (first_open_reg) begin
                        phase_next = PH_STREAM;
                    end
                end
            end
            ST_WALK_ADD: begin
                if (adv_s_reg) begin
                    pos_s_next  = pos_s_reg + POS_W'(rd_s);
                    walk_s_next = walk_s_reg + CNT_W'(1);
                end
                if (adv_u_reg) begin
                    pos_u_next  = pos_u_reg + POS_W'(rd_u);
                    walk_u_next = walk_u_reg + CNT_W'(1);
                end
            end
            ST_OPEN: begin
                if (more_groups) begin
                    grp_s_next = walk_s_reg;
                    grp_u_next = walk_u_reg;
                    cur_s_next = walk_s_reg;
                    cur_u_next = walk_u_reg;
                    adv_s_next = 1'b1;
                    adv_u_next = 1'b1;
                end else begin
                    phase_next = PH_DONE;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{split_index:   '0,
                                     unsplit_index: '0,
                                     pair_valid:    1'b0,
                                     last:          1'b0,
                                     status:        STATUS_EXHAUSTED};
                    priority if (ignored_reg) begin
                        m_data_next.last   = 1'b1;
                        m_data_next.status = STATUS_IGNORED;
                    end else if (phase_reg == PH_STREAM) begin
                        m_data_next.split_index   = idx_s_ext[INDEX_OUT_W-1:0];
                        m_data_next.unsplit_index = idx_u_ext[INDEX_OUT_W-1:0];
                        m_data_next.pair_valid    = 1'b1;
                        m_data_next.status        = STATUS_PAIR;
                        // advance unsplit first, then split, within the group
                        if (cur_u_inc >= walk_u_reg) begin
                            cur_u_next = grp_u_reg;
                            cur_s_next = cur_s_inc;
                            if (cur_s_inc >= walk_s_reg) begin
                                if (more_groups) begin
                                    first_open_next = 1'b0;
                                end else begin
                                    phase_next       = PH_DONE;
                                    m_data_next.last = 1'b1;
                                end
                            end
                        end else begin
                            cur_u_next = cur_u_inc;
                        end
                    end else begin
                        m_data_next.status = STATUS_EXHAUSTED;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            phase_reg         <= PH_LOADING;
            split_count_reg   <= '0;
            unsplit_count_reg <= '0;
            overflow_reg      <= 1'b0;
            ignored_reg       <= 1'b0;
            walk_s_reg        <= '0;
            walk_u_reg        <= '0;
            pos_s_reg         <= '0;
            pos_u_reg         <= '0;
            grp_s_reg         <= '0;
            grp_u_reg         <= '0;
            cur_s_reg         <= '0;
            cur_u_reg         <= '0;
            group_mode_reg    <= 1'b0;
            first_open_reg    <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg         <= state_next;
            phase_reg         <= phase_next;
            split_count_reg   <= split_count_next;
            unsplit_count_reg <= unsplit_count_next;
            overflow_reg      <= overflow_next;
            ignored_reg       <= ignored_next;
            walk_s_reg        <= walk_s_next;
            walk_u_reg        <= walk_u_next;
            pos_s_reg         <= pos_s_next;
            pos_u_reg         <= pos_u_next;
            grp_s_reg         <= grp_s_next;
            grp_u_reg         <= grp_u_next;
            cur_s_reg         <= cur_s_next;
            cur_u_reg         <= cur_u_next;
            group_mode_reg    <= group_mode_next;
            first_open_reg    <= first_open_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        adv_s_reg  <= adv_s_next;
        adv_u_reg  <= adv_u_next;
        m_data_reg <= m_data_next;
    end

    // walk pointers never run past the fill counts
    a_walk_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        walk_s_reg <= split_count_reg && walk_u_reg <= unsplit_count_reg)
        else $error("walk pointer past fill count");

    // once the first fetch is made, the fill counts freeze until a new line
    a_counts_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != PH_LOADING |=>
            phase_reg == PH_LOADING ||
            ($stable(split_count_reg) && $stable(unsplit_count_reg)))
        else $error("fill count changed after the first fetch");

    // between fetches of a streaming line the cursors sit inside the open group
    a_cursor_in_group: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && phase_reg == PH_STREAM && !ignored_reg) |->
            (cur_s_reg >= grp_s_reg && cur_s_reg < walk_s_reg &&
             cur_u_reg >= grp_u_reg && cur_u_reg < walk_u_reg))
        else $error("pair cursor outside the open group");

    // a pair is flagged exactly when the status says so
    a_pair_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg.pair_valid == (m_data_reg.status == STATUS_PAIR)))
        else $error("pair_valid disagrees with status");

    // an ignored line never streams pairs
    a_ignored_done: assert property (@(posedge aclk) disable iff (!aresetn)
        ignored_reg |-> phase_reg == PH_DONE)
        else $error("ignored line left in a streaming phase");

endmodule
